// ===== rtl/hics_pkg.sv =====
// ----------------------------------------------------------------------------
// hics_pkg: shared types and codes of the histogram sampler
// Request kinds, status codes, fixed field widths and sequencer states.
// ----------------------------------------------------------------------------
package hics_pkg;

    localparam int ENERGY_W = 24;
    localparam int WEIGHT_W = 16;
    localparam int UNIF_W   = 32;
    localparam int OUT_E_W  = 25;
    localparam int OUT_IX_W = 10;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FETCH_A,
        S_FETCH_B,
        S_FETCH_C,
        S_DIV,
        S_SCALE,
        S_SUM,
        S_DONE
    } state_t;

endpackage

// ===== rtl/hics_if.sv =====
// ----------------------------------------------------------------------------
// hics_req_if / hics_rsp_if: request and response channels
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface hics_req_if
    import hics_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [ENERGY_W-1:0] bin_energy;
    logic [WEIGHT_W-1:0] bin_weight;
    logic [UNIF_W-1:0]   uniform;

    modport source (output valid, kind, bin_energy, bin_weight, uniform, input ready);
    modport sink   (input valid, kind, bin_energy, bin_weight, uniform, output ready);
endinterface

interface hics_rsp_if
    import hics_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OUT_E_W-1:0]  energy;
    logic [OUT_IX_W-1:0] bin_index;
    logic [1:0]          status;

    modport source (output valid, energy, bin_index, status, input ready);
    modport sink   (input valid, energy, bin_index, status, output ready);
endinterface

// ===== rtl/histogram_inverse_cdf_sampler_top.sv =====
// ----------------------------------------------------------------------------
// histogram_inverse_cdf_sampler_top: piecewise-linear inverse CDF sampler
// Keeps a table of bins with cumulative weights and draws interpolated
// energies from it by binary search and a serial divider.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | kind, bin_energy, bin_weight, uniform
//  rsp     | out | energy, bin_index, status
//
//  Clear, append and unused requests go from idle straight to the done state.
//  A sample does a binary search on the cumulative memory read port, each step a
//  read then a compare, and the one-bit-a-cycle divider gives a 32-bit quotient.
//  A failed sample goes to done. Reset empties the table at once; memory
//  contents need no clearing. The result register lets a new request enter
//  while a result waits; a finished result holds the sequencer while rsp stalls.
// ----------------------------------------------------------------------------
module histogram_inverse_cdf_sampler_top
    import hics_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    hics_req_if.sink    req,
    hics_rsp_if.source  rsp
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CUMW = WEIGHT_W + IW;

    // Table memories.
    logic [ENERGY_W-1:0] energy_mem [TABLE_DEPTH];
    logic [CUMW-1:0]     cum_mem    [TABLE_DEPTH];
    logic [ENERGY_W-1:0] e_rd;
    logic [CUMW-1:0]     cum_rd;
    logic [IW-1:0]       e_addr;
    logic [IW-1:0]       cum_addr;
    logic                wr_en;

    // Sequencer and datapath registers.
    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CUMW-1:0]     last_cum_reg, last_cum_next;
    logic [UNIF_W-1:0]   u_reg, u_next;
    logic [63:0]         scaled_reg, scaled_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [CUMW-1:0]     cumidx_reg, cumidx_next;
    logic [CUMW-1:0]     w_reg, w_next;
    logic [CUMW-1:0]     rem_reg, rem_next;
    logic [31:0]         quo_reg, quo_next;
    logic [4:0]          div_cnt_reg, div_cnt_next;
    logic [ENERGY_W-1:0] elow_reg, elow_next;
    logic [ENERGY_W-1:0] span_reg, span_next;
    logic [55:0]         prod_reg, prod_next;
    logic [OUT_E_W-1:0]  res_e_reg, res_e_next;
    logic [OUT_IX_W-1:0] res_ix_reg, res_ix_next;
    logic [1:0]          res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_E_W-1:0]  out_e_reg, out_e_next;
    logic [OUT_IX_W-1:0] out_ix_reg, out_ix_next;
    logic [1:0]          out_st_reg, out_st_next;

    logic                accept;
    logic                out_free;
    logic [IW-1:0]       mid;
    logic [IW-1:0]       wr_addr;
    logic [CUMW-1:0]     wr_cum;
    logic [CUMW-1:0]     lowcum;
    logic [CUMW:0]       rem_shift;
    logic                rem_ge;
    logic                is_last;
    logic [31:0]         idx_ext;
    logic [31:0]         app_ext;

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign wr_addr   = count_reg[IW-1:0];
    assign wr_cum    = last_cum_reg + CUMW'(req.bin_weight);
    assign wr_en     = accept && (kind_t'(req.kind) == KIND_APPEND)
                       && (count_reg != CW'(TABLE_DEPTH));
    assign lowcum    = (lo_reg == '0) ? '0 : cum_rd;
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_ge    = rem_shift >= {1'b0, w_reg};
    assign is_last   = ({1'b0, lo_reg} + 1'b1) == (IW + 1)'(count_reg);
    assign idx_ext   = 32'(lo_reg);
    assign app_ext   = 32'(count_reg);

    // Table write on append and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            energy_mem[wr_addr] <= req.bin_energy;
            cum_mem[wr_addr]    <= wr_cum;
        end
        e_rd   <= energy_mem[e_addr];
        cum_rd <= cum_mem[cum_addr];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((kind_t'(req.kind) == KIND_SAMPLE) && (count_reg >= CW'(2))
                        && (last_cum_reg != '0))
                        state_next = S_MUL;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:      state_next = S_SRCH_RD;
            S_SRCH_RD:  state_next = (lo_reg == hi_reg) ? S_FETCH_A : S_SRCH_CMP;
            S_SRCH_CMP: state_next = S_SRCH_RD;
            S_FETCH_A:  state_next = S_FETCH_B;
            S_FETCH_B:  state_next = S_FETCH_C;
            S_FETCH_C:  state_next = S_DIV;
            S_DIV:      state_next = (div_cnt_reg == 5'd31) ? S_SCALE : S_DIV;
            S_SCALE:    state_next = S_SUM;
            S_SUM:      state_next = S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and memory read addresses.
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        e_addr    = lo_reg;
        cum_addr  = lo_reg;
        unique case (state_reg)
            S_SRCH_RD: cum_addr = mid;
            S_FETCH_B:
            begin
                cum_addr = lo_reg - 1'b1;
                e_addr   = is_last ? (count_reg[IW-1:0] - IW'(2)) : (lo_reg + 1'b1);
            end
            default:
            begin
                e_addr   = lo_reg;
                cum_addr = lo_reg;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        count_next     = count_reg;
        last_cum_next  = last_cum_reg;
        u_next         = u_reg;
        scaled_next    = scaled_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cumidx_next    = cumidx_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        elow_next      = elow_reg;
        span_next      = span_reg;
        prod_next      = prod_reg;
        res_e_next     = res_e_reg;
        res_ix_next    = res_ix_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_e_next     = out_e_reg;
        out_ix_next    = out_ix_reg;
        out_st_next    = out_st_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    u_next      = req.uniform;
                    lo_next     = '0;
                    hi_next     = count_reg[IW-1:0] - 1'b1;
                    res_e_next  = '0;
                    res_ix_next = '0;
                    res_st_next = STAT_OK;
                    unique case (kind_t'(req.kind))
                        KIND_CLEAR:
                        begin
                            count_next    = '0;
                            last_cum_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                                res_st_next = STAT_FULL;
                            else
                            begin
                                count_next    = count_reg + 1'b1;
                                last_cum_next = wr_cum;
                                res_ix_next   = app_ext[OUT_IX_W-1:0];
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            if ((count_reg < CW'(2)) || (last_cum_reg == '0))
                                res_st_next = STAT_EMPTY;
                        end
                        default: res_st_next = STAT_OK;
                    endcase
                end
            end
            // Scale the uniform fraction by the total weight.
            S_MUL: scaled_next = u_reg * 32'(last_cum_reg);
            S_SRCH_CMP:
            begin
                if (32'(cum_rd) > scaled_reg[63:32])
                    hi_next = mid;
                else
                    lo_next = mid + 1'b1;
            end
            S_FETCH_B:
            begin
                cumidx_next = cum_rd;
                elow_next   = e_rd;
            end
            // Bin weight, divider start and span of the chosen bin.
            S_FETCH_C:
            begin
                w_next       = cumidx_reg - lowcum;
                rem_next     = CUMW'(scaled_reg[63:32] - 32'(lowcum));
                quo_next     = scaled_reg[31:0];
                div_cnt_next = '0;
                if (is_last)
                    span_next = (elow_reg > e_rd) ? (elow_reg - e_rd) : '0;
                else
                    span_next = (e_rd > elow_reg) ? (e_rd - elow_reg) : '0;
            end
            // One quotient bit per cycle.
            S_DIV:
            begin
                rem_next     = rem_ge ? CUMW'(rem_shift - {1'b0, w_reg}) : CUMW'(rem_shift);
                quo_next     = {quo_reg[30:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            S_SCALE: prod_next = span_reg * quo_reg;
            S_SUM:
            begin
                res_e_next  = OUT_E_W'(elow_reg) + OUT_E_W'(prod_reg[55:32]);
                res_ix_next = idx_ext[OUT_IX_W-1:0];
                res_st_next = STAT_OK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_e_next     = res_e_reg;
                    out_ix_next    = res_ix_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default: u_next = u_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_cum_reg  <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_cum_reg  <= last_cum_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        scaled_reg <= scaled_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        cumidx_reg <= cumidx_next;
        w_reg      <= w_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        elow_reg   <= elow_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        res_e_reg  <= res_e_next;
        res_ix_reg <= res_ix_next;
        res_st_reg <= res_st_next;
        out_e_reg  <= out_e_next;
        out_ix_reg <= out_ix_next;
        out_st_reg <= out_st_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.energy    = out_e_reg;
    assign rsp.bin_index = out_ix_reg;
    assign rsp.status    = out_st_reg;

endmodule
